[hw/rtl/babs_pkg.sv]
package babs_pkg;

   localparam int unsigned LVL_W     = 4;
   localparam int unsigned REG_IDX_W = 3;
   localparam int unsigned DCASE_W   = 3;

   localparam logic [30:0] BYTE_SCALE = 31'd8000000;

   localparam logic [31:0] RST_SEG_DURATION = 32'd2000000;
   localparam logic [31:0] RST_BUF_MIN      = 32'd12000000;
   localparam logic [31:0] RST_BUF_LOW      = 32'd16000000;
   localparam logic [31:0] RST_BUF_HIGH     = 32'd20000000;
   localparam logic [31:0] RST_BUF_UPPER    = 32'd30000000;
   localparam logic [3:0]  RST_TOP_LEVEL    = 4'd15;

   typedef enum logic [DCASE_W-1:0] {
      DC_FIRST     = 3'd0,
      DC_PANIC     = 3'd1,
      DC_STEP_DOWN = 3'd2,
      DC_STEP_UP   = 3'd3,
      DC_HOLD      = 3'd4,
      DC_BEST_FIT  = 3'd5
   } dcase_type;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_SEG_DURATION = 3'd0,
      REG_BUF_MIN      = 3'd1,
      REG_BUF_LOW      = 3'd2,
      REG_BUF_HIGH     = 3'd3,
      REG_BUF_UPPER    = 3'd4,
      REG_TOP_LEVEL    = 3'd5
   } reg_type;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_DECIDE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      SK_LAST = 2'd0,
      SK_DOWN = 2'd1,
      SK_UP   = 2'd2,
      SK_BEST = 2'd3
   } scan_type;

endpackage

[hw/rtl/babs_ram.sv]
module babs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[hw/rtl/buffer_aware_bitrate_select_top.sv]
// A size load writes the size table, and the block is ready again in the next cycle.
// A decision goes from the prepare state straight to the finish state (first
// segment, panic), or else through a walk over the size table: one level per
// cycle through the shared multiplier, after the margin product is formed.
// Throughput is one request at a time; reset is synchronous and active high,
// restores the register defaults and level 0, and leaves the size table unset.
module buffer_aware_bitrate_select_top #(
   parameter int MAX_LEVELS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_op,
   input  logic [babs_pkg::LVL_W-1:0]          req_level_index,
   input  logic [31:0]                         req_segment_bytes,
   input  logic                                req_first_segment,
   input  logic signed [31:0]                  req_buffer_level_us,
   input  logic [30:0]                         req_elapsed_us,
   input  logic [33:0]                         req_bandwidth_bps,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [babs_pkg::LVL_W-1:0]          rsp_chosen_level,
   output logic [babs_pkg::DCASE_W-1:0]        rsp_decision_case,
   output logic [31:0]                         rsp_download_delay_us,
   output logic                                rsp_delay_applied,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [babs_pkg::REG_IDX_W-1:0]      csr_index,
   input  logic [31:0]                         csr_wdata
);

   import babs_pkg::*;

   localparam int AW      = $clog2(MAX_LEVELS);
   localparam int TOP_CAP = (MAX_LEVELS - 1 > 15) ? 15 : MAX_LEVELS - 1;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_PREP  = 5'b00010,
      ST_AVAIL = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_FIN   = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [31:0]       dur_ff, dur_in;
   logic [31:0]       min_ff, min_in;
   logic [31:0]       low_ff, low_in;
   logic [31:0]       high_ff, high_in;
   logic [31:0]       upper_ff, upper_in;
   logic [3:0]        top_level_ff, top_level_in;
   logic [3:0]        last_ff, last_in;

   logic              first_ff, first_in;
   logic [33:0]       bw_ff, bw_in;
   logic signed [33:0] now_ff, now_in;
   logic [30:0]       mmin_ff, mmin_in;
   logic [30:0]       mlow_ff, mlow_in;
   logic              low_band_ff, low_band_in;
   logic              above_ff, above_in;
   logic              applied_ff, applied_in;
   logic [30:0]       dhi_ff, dhi_in;
   logic [33:0]       ovl_ff, ovl_in;

   logic [64:0]       avail_ff, avail_in;
   logic [64:0]       need_ff, need_in;
   scan_type          kind_ff, kind_in;
   logic [3:0]        scan_idx_ff, scan_idx_in;
   logic [4:0]        left_ff, left_in;
   logic              p1_vld_ff, p1_vld_in;
   logic [3:0]        p1_idx_ff, p1_idx_in;
   logic              p2_vld_ff, p2_vld_in;
   logic [3:0]        p2_idx_ff, p2_idx_in;

   logic [3:0]        res_lvl_ff, res_lvl_in;
   dcase_type         res_case_ff, res_case_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [3:0]        out_lvl_ff, out_lvl_in;
   dcase_type         out_case_ff, out_case_in;
   logic [31:0]       out_delay_ff, out_delay_in;
   logic              out_applied_ff, out_applied_in;

   logic              req_fire;
   logic              csr_fire;
   logic              ram_we;
   logic              ram_re;
   logic [31:0]       ram_rdata;
   logic [33:0]       mul_a;
   logic [30:0]       mul_b;
   logic [64:0]       product;
   logic [3:0]        top_eff;

   logic signed [34:0] now_x;
   logic signed [34:0] mmin_x;
   logic signed [34:0] mlow_x;
   logic signed [34:0] dhi_x;
   logic signed [34:0] ovl_x;
   logic [34:0]        dsum;

   logic              fit;
   logic              want;
   logic              hit;
   logic              exhausted;
   logic [3:0]        down_base;

   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   assign ram_we = req_fire && (req_op == OP_LOAD) &&
                   ({28'd0, req_level_index} < 32'(MAX_LEVELS));

   babs_ram #(
      .WIDTH (32),
      .DEPTH (MAX_LEVELS)
   ) u_size_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (AW'(req_level_index)),
      .wr_data (req_segment_bytes),
      .rd_en   (ram_re),
      .rd_addr (AW'(scan_idx_ff)),
      .rd_data (ram_rdata)
   );

   assign top_eff = (top_level_ff > 4'(TOP_CAP)) ? 4'(TOP_CAP) : top_level_ff;

   assign now_x  = {now_ff[33], now_ff};
   assign mmin_x = now_x - $signed({3'd0, min_ff});
   assign mlow_x = now_x - $signed({3'd0, low_ff});
   assign dhi_x  = now_x - $signed({3'd0, high_ff});
   assign ovl_x  = $signed({3'd0, high_ff}) - $signed({3'd0, upper_ff}) +
                   $signed({3'd0, dur_ff});

   assign dsum = {4'd0, dhi_ff} + {1'b0, ovl_ff};

   assign mul_a   = (state_ff == ST_AVAIL) ? bw_ff : {2'd0, ram_rdata};
   assign mul_b   = (state_ff == ST_AVAIL) ? ((kind_ff == SK_BEST) ? mlow_ff : mmin_ff)
                                           : BYTE_SCALE;
   assign product = {31'd0, mul_a} * {34'd0, mul_b};

   assign fit       = (bw_ff != 34'd0) && (need_ff <= avail_ff);
   assign want      = (kind_ff == SK_UP) || (kind_ff == SK_BEST);
   assign hit       = p2_vld_ff && (fit == want);
   assign exhausted = (left_ff == 5'd0) && !p1_vld_ff && !p2_vld_ff;
   assign down_base = hit ? p2_idx_ff : last_ff;

   always_comb begin
      state_in       = state_ff;
      dur_in         = dur_ff;
      min_in         = min_ff;
      low_in         = low_ff;
      high_in        = high_ff;
      upper_in       = upper_ff;
      top_level_in   = top_level_ff;
      last_in        = last_ff;
      first_in       = first_ff;
      bw_in          = bw_ff;
      now_in         = now_ff;
      mmin_in        = mmin_ff;
      mlow_in        = mlow_ff;
      low_band_in    = low_band_ff;
      above_in       = above_ff;
      applied_in     = applied_ff;
      dhi_in         = dhi_ff;
      ovl_in         = ovl_ff;
      avail_in       = avail_ff;
      need_in        = need_ff;
      kind_in        = kind_ff;
      scan_idx_in    = scan_idx_ff;
      left_in        = left_ff;
      p1_vld_in      = p1_vld_ff;
      p1_idx_in      = p1_idx_ff;
      p2_vld_in      = p2_vld_ff;
      p2_idx_in      = p2_idx_ff;
      res_lvl_in     = res_lvl_ff;
      res_case_in    = res_case_ff;
      rsp_valid_in   = rsp_valid_ff;
      out_lvl_in     = out_lvl_ff;
      out_case_in    = out_case_ff;
      out_delay_in   = out_delay_ff;
      out_applied_in = out_applied_ff;
      ram_re         = 1'b0;

      if (csr_fire) begin
         unique case (csr_index)
            REG_SEG_DURATION: dur_in       = csr_wdata;
            REG_BUF_MIN:      min_in       = csr_wdata;
            REG_BUF_LOW:      low_in       = csr_wdata;
            REG_BUF_HIGH:     high_in      = csr_wdata;
            REG_BUF_UPPER:    upper_in     = csr_wdata;
            REG_TOP_LEVEL:    top_level_in = csr_wdata[3:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_op == OP_DECIDE)) begin
               first_in = req_first_segment;
               bw_in    = req_bandwidth_bps;
               now_in   = $signed({{2{req_buffer_level_us[31]}}, req_buffer_level_us}) -
                          $signed({3'd0, req_elapsed_us});
               state_in = ST_PREP;
            end
         end

         ST_PREP: begin
            mmin_in     = mmin_x[30:0];
            mlow_in     = mlow_x[30:0];
            low_band_in = (mlow_x <= 35'sd0);
            above_in    = (dhi_x > 35'sd0);
            applied_in  = !first_ff && (dhi_x > 35'sd0);
            dhi_in      = (!first_ff && (dhi_x > 35'sd0)) ? dhi_x[30:0] : 31'd0;
            ovl_in      = (ovl_x > 35'sd0) ? ovl_x[33:0] : 34'd0;
            if (first_ff) begin
               res_lvl_in  = last_ff;
               res_case_in = DC_FIRST;
               state_in    = ST_FIN;
            end else if (mmin_x <= 35'sd0) begin
               res_lvl_in  = 4'd0;
               res_case_in = DC_PANIC;
               state_in    = ST_FIN;
            end else begin
               kind_in     = SK_LAST;
               scan_idx_in = last_ff;
               left_in     = 5'd1;
               state_in    = ST_AVAIL;
            end
         end

         ST_AVAIL: begin
            avail_in  = product;
            p1_vld_in = 1'b0;
            p2_vld_in = 1'b0;
            state_in  = ST_SCAN;
         end

         ST_SCAN: begin
            p2_vld_in = p1_vld_ff;
            p2_idx_in = p1_idx_ff;
            need_in   = product;
            p1_vld_in = (left_ff != 5'd0);
            p1_idx_in = scan_idx_ff;
            if (left_ff != 5'd0) begin
               ram_re      = 1'b1;
               left_in     = left_ff - 5'd1;
               scan_idx_in = (kind_ff == SK_DOWN) ? scan_idx_ff + 4'd1 : scan_idx_ff - 4'd1;
            end
            if (hit || exhausted) begin
               p1_vld_in = 1'b0;
               p2_vld_in = 1'b0;
               left_in   = 5'd0;
               unique case (kind_ff)
                  SK_LAST: begin
                     if (hit) begin
                        kind_in     = SK_DOWN;
                        scan_idx_in = 4'd0;
                        left_in     = {1'b0, last_ff};
                     end else if (low_band_ff) begin
                        if (last_ff < top_eff) begin
                           kind_in     = SK_UP;
                           scan_idx_in = last_ff + 4'd1;
                           left_in     = 5'd1;
                        end else begin
                           res_lvl_in  = last_ff;
                           res_case_in = DC_HOLD;
                           state_in    = ST_FIN;
                        end
                     end else begin
                        kind_in     = SK_BEST;
                        scan_idx_in = top_eff;
                        left_in     = (top_eff >= last_ff) ?
                                      5'(top_eff) - 5'(last_ff) + 5'd1 : 5'd0;
                        if (above_ff) begin
                           state_in = ST_AVAIL;
                        end
                     end
                  end
                  SK_DOWN: begin
                     res_lvl_in  = (down_base == 4'd0) ? 4'd0 : down_base - 4'd1;
                     res_case_in = DC_STEP_DOWN;
                     state_in    = ST_FIN;
                  end
                  SK_UP: begin
                     res_lvl_in  = hit ? last_ff + 4'd1 : last_ff;
                     res_case_in = hit ? DC_STEP_UP : DC_HOLD;
                     state_in    = ST_FIN;
                  end
                  SK_BEST: begin
                     if (hit) begin
                        res_lvl_in = p2_idx_ff;
                     end else if (top_eff >= last_ff) begin
                        res_lvl_in = (last_ff == 4'd0) ? 4'd0 : last_ff - 4'd1;
                     end else begin
                        res_lvl_in = top_eff;
                     end
                     res_case_in = DC_BEST_FIT;
                     state_in    = ST_FIN;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end

         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               out_lvl_in     = res_lvl_ff;
               out_case_in    = res_case_ff;
               out_applied_in = applied_ff;
               out_delay_in   = (dsum[34:32] != 3'd0) ? 32'hFFFF_FFFF : dsum[31:0];
               last_in        = res_lvl_ff;
               state_in       = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dur_ff       <= RST_SEG_DURATION;
         min_ff       <= RST_BUF_MIN;
         low_ff       <= RST_BUF_LOW;
         high_ff      <= RST_BUF_HIGH;
         upper_ff     <= RST_BUF_UPPER;
         top_level_ff <= RST_TOP_LEVEL;
         last_ff      <= 4'd0;
         left_ff      <= 5'd0;
         p1_vld_ff    <= 1'b0;
         p2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dur_ff       <= dur_in;
         min_ff       <= min_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         upper_ff     <= upper_in;
         top_level_ff <= top_level_in;
         last_ff      <= last_in;
         left_ff      <= left_in;
         p1_vld_ff    <= p1_vld_in;
         p2_vld_ff    <= p2_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff       <= first_in;
      bw_ff          <= bw_in;
      now_ff         <= now_in;
      mmin_ff        <= mmin_in;
      mlow_ff        <= mlow_in;
      low_band_ff    <= low_band_in;
      above_ff       <= above_in;
      applied_ff     <= applied_in;
      dhi_ff         <= dhi_in;
      ovl_ff         <= ovl_in;
      avail_ff       <= avail_in;
      need_ff        <= need_in;
      kind_ff        <= kind_in;
      scan_idx_ff    <= scan_idx_in;
      p1_idx_ff      <= p1_idx_in;
      p2_idx_ff      <= p2_idx_in;
      res_lvl_ff     <= res_lvl_in;
      res_case_ff    <= res_case_in;
      out_lvl_ff     <= out_lvl_in;
      out_case_ff    <= out_case_in;
      out_delay_ff   <= out_delay_in;
      out_applied_ff <= out_applied_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_chosen_level      = out_lvl_ff;
   assign rsp_decision_case     = out_case_ff;
   assign rsp_download_delay_us = out_delay_ff;
   assign rsp_delay_applied     = out_applied_ff;

`ifndef SYNTHESIS
   a_pipe_in_scan: assert property (@(posedge clock) disable iff (reset)
      (p1_vld_ff || p2_vld_ff) |-> (state_ff == ST_SCAN))
      else $error("table walk pipeline busy outside the scan state");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("result raised without a finished decision");

   a_first_no_delay: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (out_case_ff == DC_FIRST)) |-> !out_applied_ff)
      else $error("first segment reported an applied delay");

   a_panic_level_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (out_case_ff == DC_PANIC)) |-> (out_lvl_ff == 4'd0))
      else $error("panic decision did not select level zero");
`endif

endmodule
